/* src/dns_response_parser_core_defines.svh */
`ifndef DNS_RESPONSE_PARSER_CORE_DEFINES_SVH
`define DNS_RESPONSE_PARSER_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define DNSRP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define DNSRP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/dnsrp_pkg.sv */
package dnsrp_pkg;

    localparam int MSG_BYTES = 512;
    localparam int POS_W     = $clog2(MSG_BYTES + 1);

    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MSG_BYTES);

    localparam logic [7:0] PTR_MARK  = 8'hC0;
    localparam logic [3:0] HDR_RCODE = 4'd3;
    localparam logic [3:0] HDR_QD_HI = 4'd4;
    localparam logic [3:0] HDR_QD_LO = 4'd5;
    localparam logic [3:0] HDR_AN_HI = 4'd6;
    localparam logic [3:0] HDR_AN_LO = 4'd7;
    localparam logic [3:0] HDR_LAST  = 4'd11;
    localparam logic [3:0] QFIX_LEN  = 4'd4;
    localparam logic [3:0] AFIX_LEN  = 4'd10;

    localparam logic [1:0] KIND_ERR    = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_RDATA  = 2'd2;
    localparam logic [1:0] KIND_END    = 2'd3;

    localparam logic [1:0] STAT_COMPLETE  = 2'd0;
    localparam logic [1:0] STAT_TRUNCATED = 2'd1;
    localparam logic [1:0] STAT_REPLY_ERR = 2'd2;

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       final_byte;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [3:0]  resp_code;
        logic [15:0] answer_number;
        logic [15:0] record_type;
        logic [15:0] record_class;
        logic [31:0] time_to_live;
        logic [13:0] name_offset;
        logic [15:0] rdata_length;
        logic [7:0]  rdata_value;
        logic [1:0]  end_status;
        logic        run_last;
    } out_word_t;

endpackage

/* src/dns_response_parser_core.sv */
// channel | direction | handshake         | word
// s_      | in        | s_valid / s_ready | dnsrp_pkg::in_word_t
// m_      | out       | m_valid / m_ready | dnsrp_pkg::out_word_t
//
// One message byte is taken per cycle while s_ready is high; its results are known in the same cycle.
// A byte that yields two results (error, answer header or rdata, plus end) fills
// both entries of the two-word result buffer, so s_ready drops until a word is taken.
// s_ready is high while the buffer is empty, or holds one word being taken.
// aresetn is synchronous, active low: parser returns to the header phase.
`include "dns_response_parser_core_defines.svh"

module dns_response_parser_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  dnsrp_pkg::in_word_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output dnsrp_pkg::out_word_t m_data
);

    typedef enum logic [3:0] {
        PH_HEADER,
        PH_QNAME,
        PH_QFIXED,
        PH_ANAME,
        PH_ANAME_REST,
        PH_APTR2,
        PH_AFIXED,
        PH_RDATA,
        PH_DONE,
        PH_DROP
    } phase_t;

    phase_t                      phase_reg, phase_next;
    logic [dnsrp_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [3:0]                  fbc_reg, fbc_next;
    logic [15:0]                 qleft_reg, qleft_next;
    logic [15:0]                 aleft_reg, aleft_next;
    logic [15:0]                 aidx_reg, aidx_next;
    logic [15:0]                 type_reg, type_next;
    logic [15:0]                 class_reg, class_next;
    logic [31:0]                 ttl_reg, ttl_next;
    logic [15:0]                 rleft_reg, rleft_next;
    logic [15:0]                 rtotal_reg, rtotal_next;
    logic [13:0]                 nstart_reg, nstart_next;
    logic [3:0]                  rcode_reg, rcode_next;

    logic [1:0]           count_reg;
    dnsrp_pkg::out_word_t slot0_reg, slot1_reg;

    logic                 s_fire, pop;
    logic [7:0]           b;
    logic                 fin, sect, prim_valid;
    logic [1:0]           prim_kind, status;
    logic [1:0]           n_res;
    dnsrp_pkg::out_word_t res_prim, res_end, res_a, res_b;

    assign m_valid = (count_reg != 2'd0);
    assign m_data  = slot0_reg;
    assign pop     = m_valid && m_ready;
    assign s_ready = (count_reg == 2'd0) || (count_reg == 2'd1 && m_ready);
    assign s_fire  = s_valid && s_ready;
    assign b       = s_data.msg_byte;
    assign fin     = s_data.final_byte;

    always_comb begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        fbc_next    = fbc_reg;
        qleft_next  = qleft_reg;
        aleft_next  = aleft_reg;
        aidx_next   = aidx_reg;
        type_next   = type_reg;
        class_next  = class_reg;
        ttl_next    = ttl_reg;
        rleft_next  = rleft_reg;
        rtotal_next = rtotal_reg;
        nstart_next = nstart_reg;
        rcode_next  = rcode_reg;
        sect        = 1'b0;
        prim_valid  = 1'b0;
        prim_kind   = dnsrp_pkg::KIND_ERR;

        if (pos_reg < dnsrp_pkg::POS_LIMIT) begin
            pos_next = pos_reg + 1'b1;
            unique case (phase_reg)
                PH_HEADER: begin
                    fbc_next = fbc_reg + 1'b1;
                    if (fbc_reg == dnsrp_pkg::HDR_RCODE) begin
                        rcode_next = b[3:0];
                    end
                    if (fbc_reg == dnsrp_pkg::HDR_QD_HI) begin
                        qleft_next = {b, 8'h00};
                    end
                    if (fbc_reg == dnsrp_pkg::HDR_QD_LO) begin
                        qleft_next = {qleft_reg[15:8], b};
                    end
                    if (fbc_reg == dnsrp_pkg::HDR_AN_HI) begin
                        aleft_next = {b, 8'h00};
                    end
                    if (fbc_reg == dnsrp_pkg::HDR_AN_LO) begin
                        aleft_next = {aleft_reg[15:8], b};
                    end
                    if (fbc_reg == dnsrp_pkg::HDR_RCODE && b[3:0] != 4'd0) begin
                        prim_valid = 1'b1;
                        prim_kind  = dnsrp_pkg::KIND_ERR;
                        phase_next = PH_DROP;
                    end else if (fbc_reg == dnsrp_pkg::HDR_LAST) begin
                        sect = 1'b1;
                    end
                end
                PH_QNAME: begin
                    if (b == 8'd0) begin
                        phase_next = PH_QFIXED;
                        fbc_next   = 4'd0;
                    end
                end
                PH_QFIXED: begin
                    fbc_next = fbc_reg + 1'b1;
                    if (fbc_next >= dnsrp_pkg::QFIX_LEN) begin
                        qleft_next = qleft_reg - 1'b1;
                        sect       = 1'b1;
                    end
                end
                PH_ANAME: begin
                    fbc_next = 4'd0;
                    if ((b & dnsrp_pkg::PTR_MARK) == dnsrp_pkg::PTR_MARK) begin
                        nstart_next = {b[5:0], 8'h00};
                        phase_next  = PH_APTR2;
                    end else begin
                        nstart_next = 14'(pos_reg);
                        phase_next  = (b == 8'd0) ? PH_AFIXED : PH_ANAME_REST;
                    end
                end
                PH_ANAME_REST: begin
                    if (b == 8'd0) begin
                        phase_next = PH_AFIXED;
                        fbc_next   = 4'd0;
                    end
                end
                PH_APTR2: begin
                    nstart_next = nstart_reg | {6'd0, b};
                    phase_next  = PH_AFIXED;
                    fbc_next    = 4'd0;
                end
                PH_AFIXED: begin
                    if (fbc_reg < 4'd2) begin
                        type_next = {type_reg[7:0], b};
                    end else if (fbc_reg < 4'd4) begin
                        class_next = {class_reg[7:0], b};
                    end else if (fbc_reg < 4'd8) begin
                        ttl_next = {ttl_reg[23:0], b};
                    end else begin
                        rtotal_next = {rtotal_reg[7:0], b};
                    end
                    fbc_next = fbc_reg + 1'b1;
                    if ({1'b0, fbc_reg} + 5'd1 >= {1'b0, dnsrp_pkg::AFIX_LEN}) begin
                        fbc_next   = 4'd0;
                        rleft_next = rtotal_next;
                        prim_valid = 1'b1;
                        prim_kind  = dnsrp_pkg::KIND_HEADER;
                        if (rtotal_next == 16'd0) begin
                            aidx_next  = aidx_reg + 1'b1;
                            aleft_next = aleft_reg - 1'b1;
                            sect       = 1'b1;
                        end else begin
                            phase_next = PH_RDATA;
                        end
                    end
                end
                PH_RDATA: begin
                    prim_valid = 1'b1;
                    prim_kind  = dnsrp_pkg::KIND_RDATA;
                    rleft_next = rleft_reg - 1'b1;
                    if (rleft_next == 16'd0) begin
                        aidx_next  = aidx_reg + 1'b1;
                        aleft_next = aleft_reg - 1'b1;
                        sect       = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        if (sect) begin
            fbc_next = 4'd0;
            if (qleft_next != 16'd0) begin
                phase_next = PH_QNAME;
            end else if (aleft_next != 16'd0) begin
                phase_next = PH_ANAME;
            end else begin
                phase_next = PH_DONE;
            end
        end

        if (phase_next == PH_DROP) begin
            status = dnsrp_pkg::STAT_REPLY_ERR;
        end else if (phase_next == PH_DONE) begin
            status = dnsrp_pkg::STAT_COMPLETE;
        end else begin
            status = dnsrp_pkg::STAT_TRUNCATED;
        end

        res_prim               = '0;
        res_prim.result_kind   = prim_kind;
        res_prim.resp_code     = rcode_next;
        res_prim.run_last      = !fin;
        if (prim_kind != dnsrp_pkg::KIND_ERR) begin
            res_prim.answer_number = aidx_reg;
            res_prim.record_type   = type_next;
            res_prim.record_class  = class_next;
            res_prim.time_to_live  = ttl_next;
            res_prim.name_offset   = nstart_next;
            res_prim.rdata_length  = rtotal_next;
        end
        if (prim_kind == dnsrp_pkg::KIND_RDATA) begin
            res_prim.rdata_value = b;
        end

        res_end               = '0;
        res_end.result_kind   = dnsrp_pkg::KIND_END;
        res_end.resp_code     = rcode_next;
        res_end.answer_number = aidx_next;
        res_end.end_status    = status;
        res_end.run_last      = 1'b1;

        res_a = res_prim;
        res_b = res_end;
        if (prim_valid && fin) begin
            n_res = 2'd2;
        end else if (prim_valid) begin
            n_res = 2'd1;
        end else if (fin) begin
            n_res = 2'd1;
            res_a = res_end;
        end else begin
            n_res = 2'd0;
        end

        if (fin) begin
            phase_next  = PH_HEADER;
            pos_next    = '0;
            fbc_next    = 4'd0;
            qleft_next  = 16'd0;
            aleft_next  = 16'd0;
            aidx_next   = 16'd0;
            type_next   = 16'd0;
            class_next  = 16'd0;
            ttl_next    = 32'd0;
            rleft_next  = 16'd0;
            rtotal_next = 16'd0;
            nstart_next = 14'd0;
            rcode_next  = 4'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HEADER;
            pos_reg    <= '0;
            fbc_reg    <= 4'd0;
            qleft_reg  <= 16'd0;
            aleft_reg  <= 16'd0;
            aidx_reg   <= 16'd0;
            type_reg   <= 16'd0;
            class_reg  <= 16'd0;
            ttl_reg    <= 32'd0;
            rleft_reg  <= 16'd0;
            rtotal_reg <= 16'd0;
            nstart_reg <= 14'd0;
            rcode_reg  <= 4'd0;
            count_reg  <= 2'd0;
        end else begin
            if (s_fire) begin
                phase_reg  <= phase_next;
                pos_reg    <= pos_next;
                fbc_reg    <= fbc_next;
                qleft_reg  <= qleft_next;
                aleft_reg  <= aleft_next;
                aidx_reg   <= aidx_next;
                type_reg   <= type_next;
                class_reg  <= class_next;
                ttl_reg    <= ttl_next;
                rleft_reg  <= rleft_next;
                rtotal_reg <= rtotal_next;
                nstart_reg <= nstart_next;
                rcode_reg  <= rcode_next;
            end
            // a taken input word replaces the buffer contents with its own results
            if (s_fire) begin
                slot0_reg <= res_a;
                slot1_reg <= res_b;
                count_reg <= n_res;
            end else if (pop) begin
                slot0_reg <= slot1_reg;
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `DNSRP_ASSERT_NOW(a_two_ends_with_end, s_fire && n_res == 2'd2,
        res_b.result_kind == dnsrp_pkg::KIND_END, "second result of a byte is not an end word")
    `DNSRP_ASSERT_NEXT(a_final_restarts, s_fire && fin,
        phase_reg == PH_HEADER && pos_reg == '0, "parser did not restart after final byte")
    `DNSRP_ASSERT_NOW(a_pos_bounded, 1'b1,
        pos_reg <= dnsrp_pkg::POS_LIMIT, "byte position ran past the message bound")
    `DNSRP_ASSERT_NOW(a_end_is_last, m_valid && m_data.result_kind == dnsrp_pkg::KIND_END,
        m_data.run_last, "end word not marked as last of its byte")
    `DNSRP_ASSERT_NOW(a_drop_has_rcode, phase_reg == PH_DROP,
        rcode_reg != 4'd0, "drop phase without a nonzero reply code")

endmodule

/* dv/tb_dns_response_parser_core.sv */
`timescale 1ns / 100ps

module tb_dns_response_parser_core;

    localparam int LIMIT_NS    = 12_000_000;
    localparam int DRAIN_LIMIT = 5000;
    localparam int ITEM_TARGET = 1800;

    typedef enum logic [3:0] {
        ST_HEADER, ST_QNAME, ST_QFIXED, ST_ANAME, ST_ANAME_TAIL,
        ST_PTR_LOW, ST_AFIXED, ST_RDATA, ST_DONE, ST_DROP
    } parse_st_t;

    class dns_reply_board;
        parse_st_t             st;
        int                    pos;
        logic [3:0]            fcnt;
        logic [15:0]           q_left, a_left, a_idx;
        logic [15:0]           rtype, rclass, rd_left, rd_total;
        logic [31:0]           ttl;
        logic [13:0]           name_at;
        logic [3:0]            rcode;
        dnsrp_pkg::out_word_t  awaited[$];
        dnsrp_pkg::out_word_t  burst[$];
        int                    errors;
        int                    checked;
        int                    kind_seen[4];

        function new();
            clear();
            errors  = 0;
            checked = 0;
            foreach (kind_seen[k]) kind_seen[k] = 0;
        endfunction

        function void clear();
            st       = ST_HEADER;
            pos      = 0;
            fcnt     = '0;
            q_left   = '0;
            a_left   = '0;
            a_idx    = '0;
            rtype    = '0;
            rclass   = '0;
            ttl      = '0;
            rd_left  = '0;
            rd_total = '0;
            name_at  = '0;
            rcode    = '0;
        endfunction

        function void queue_result(logic [1:0] kind, logic [7:0] val, logic [1:0] status);
            dnsrp_pkg::out_word_t r;
            logic                 rec;
            rec = (kind == dnsrp_pkg::KIND_HEADER) || (kind == dnsrp_pkg::KIND_RDATA);
            r               = '0;
            r.result_kind   = kind;
            r.resp_code     = rcode;
            r.answer_number = (kind == dnsrp_pkg::KIND_ERR) ? 16'd0 : a_idx;
            if (rec) begin
                r.record_type  = rtype;
                r.record_class = rclass;
                r.time_to_live = ttl;
                r.name_offset  = name_at;
                r.rdata_length = rd_total;
            end
            if (kind == dnsrp_pkg::KIND_RDATA) r.rdata_value = val;
            if (kind == dnsrp_pkg::KIND_END) r.end_status = status;
            burst.push_back(r);
        endfunction

        function void pick_section();
            fcnt = '0;
            if (q_left != 0) st = ST_QNAME;
            else if (a_left != 0) st = ST_ANAME;
            else st = ST_DONE;
        endfunction

        function void close_answer();
            a_idx  = a_idx + 16'd1;
            a_left = a_left - 16'd1;
            pick_section();
        endfunction

        function void parse(logic [7:0] b);
            logic [3:0] idx;
            idx = fcnt;
            case (st)
                ST_HEADER: begin
                    if (idx == dnsrp_pkg::HDR_RCODE) rcode = b[3:0];
                    else if (idx == dnsrp_pkg::HDR_QD_HI) q_left = {b, 8'h00};
                    else if (idx == dnsrp_pkg::HDR_QD_LO) q_left = q_left | {8'h00, b};
                    else if (idx == dnsrp_pkg::HDR_AN_HI) a_left = {b, 8'h00};
                    else if (idx == dnsrp_pkg::HDR_AN_LO) a_left = a_left | {8'h00, b};
                    fcnt = idx + 4'd1;
                    if (idx == dnsrp_pkg::HDR_RCODE && rcode != 0) begin
                        queue_result(dnsrp_pkg::KIND_ERR, 8'h00, dnsrp_pkg::STAT_COMPLETE);
                        st = ST_DROP;
                    end else if (idx == dnsrp_pkg::HDR_LAST) begin
                        pick_section();
                    end
                end
                ST_QNAME: begin
                    if (b == 0) begin
                        st   = ST_QFIXED;
                        fcnt = '0;
                    end
                end
                ST_QFIXED: begin
                    fcnt = idx + 4'd1;
                    if (fcnt >= dnsrp_pkg::QFIX_LEN) begin
                        q_left = q_left - 16'd1;
                        pick_section();
                    end
                end
                ST_ANAME: begin
                    fcnt = '0;
                    if ((b & dnsrp_pkg::PTR_MARK) == dnsrp_pkg::PTR_MARK) begin
                        name_at = {b[5:0], 8'h00};
                        st      = ST_PTR_LOW;
                    end else begin
                        name_at = 14'(pos);
                        st      = (b == 0) ? ST_AFIXED : ST_ANAME_TAIL;
                    end
                end
                ST_ANAME_TAIL: begin
                    if (b == 0) begin
                        st   = ST_AFIXED;
                        fcnt = '0;
                    end
                end
                ST_PTR_LOW: begin
                    name_at = name_at | {6'd0, b};
                    st      = ST_AFIXED;
                    fcnt    = '0;
                end
                ST_AFIXED: begin
                    if (idx < 2) rtype = {rtype[7:0], b};
                    else if (idx < 4) rclass = {rclass[7:0], b};
                    else if (idx < 8) ttl = {ttl[23:0], b};
                    else rd_total = {rd_total[7:0], b};
                    fcnt = idx + 4'd1;
                    if (fcnt == dnsrp_pkg::AFIX_LEN) begin
                        fcnt    = '0;
                        rd_left = rd_total;
                        queue_result(dnsrp_pkg::KIND_HEADER, 8'h00, dnsrp_pkg::STAT_COMPLETE);
                        if (rd_left == 0) close_answer();
                        else st = ST_RDATA;
                    end
                end
                ST_RDATA: begin
                    queue_result(dnsrp_pkg::KIND_RDATA, b, dnsrp_pkg::STAT_COMPLETE);
                    rd_left = rd_left - 16'd1;
                    if (rd_left == 0) close_answer();
                end
                default: begin
                end
            endcase
        endfunction

        function void note_byte(dnsrp_pkg::in_word_t w);
            logic [1:0] status;
            burst.delete();
            if (pos < dnsrp_pkg::MSG_BYTES) begin
                parse(w.msg_byte);
                pos++;
            end
            if (w.final_byte) begin
                status = (st == ST_DROP) ? dnsrp_pkg::STAT_REPLY_ERR :
                         (st == ST_DONE) ? dnsrp_pkg::STAT_COMPLETE :
                                           dnsrp_pkg::STAT_TRUNCATED;
                queue_result(dnsrp_pkg::KIND_END, 8'h00, status);
                clear();
            end
            if (burst.size() > 0) burst[burst.size() - 1].run_last = 1'b1;
            foreach (burst[i]) awaited.push_back(burst[i]);
        endfunction

        task report(string msg);
            if (errors < 40) $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        task match_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("result %0d %s got %0h want %0h", checked, name, got, want));
        endtask

        task check_result(dnsrp_pkg::out_word_t got);
            dnsrp_pkg::out_word_t want;
            if (awaited.size() == 0) begin
                report($sformatf("result kind %0d with nothing pending", got.result_kind));
                return;
            end
            want = awaited.pop_front();
            checked++;
            kind_seen[want.result_kind]++;
            match_field("result_kind", got.result_kind, want.result_kind);
            match_field("resp_code", got.resp_code, want.resp_code);
            match_field("answer_number", got.answer_number, want.answer_number);
            match_field("record_type", got.record_type, want.record_type);
            match_field("record_class", got.record_class, want.record_class);
            match_field("time_to_live", got.time_to_live, want.time_to_live);
            match_field("name_offset", got.name_offset, want.name_offset);
            match_field("rdata_length", got.rdata_length, want.rdata_length);
            match_field("rdata_value", got.rdata_value, want.rdata_value);
            match_field("end_status", got.end_status, want.end_status);
            match_field("run_last", got.run_last, want.run_last);
        endtask
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    dnsrp_pkg::in_word_t  s_data;
    logic                 m_valid;
    logic                 m_ready;
    dnsrp_pkg::out_word_t m_data;

    dns_reply_board book = new();

    logic [7:0] msg_q[$];
    int         send_idle_pct;
    int         recv_idle_pct;
    int         recv_hold;
    int         bytes_sent;
    int         msgs_sent;

    dns_response_parser_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) book.note_byte(s_data);
            if (m_valid && m_ready) book.check_result(m_data);
        end
    end

    function automatic int pick_gap(int pct);
        if ($urandom_range(0, 99) >= pct) return 0;
        if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (recv_hold > 0) begin
            recv_hold = recv_hold - 1;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 99) < recv_idle_pct) begin
            recv_hold = pick_gap(100) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic void add_header(logic [3:0] rc, logic [15:0] qd, logic [15:0] an);
        msg_q.push_back(pick_byte());
        msg_q.push_back(pick_byte());
        msg_q.push_back(pick_byte());
        msg_q.push_back({4'($urandom), rc});
        msg_q.push_back(qd[15:8]);
        msg_q.push_back(qd[7:0]);
        msg_q.push_back(an[15:8]);
        msg_q.push_back(an[7:0]);
        repeat (4) msg_q.push_back(pick_byte());
    endfunction

    function automatic void add_question();
        repeat ($urandom_range(0, 6)) msg_q.push_back(8'($urandom_range(1, 255)));
        msg_q.push_back(8'h00);
        repeat (4) msg_q.push_back(pick_byte());
    endfunction

    function automatic void add_answer_head(logic [15:0] rdlen);
        logic [7:0] b;
        case ($urandom_range(0, 2))
            0: begin
                b = pick_byte();
                msg_q.push_back({2'b11, b[5:0]});
                msg_q.push_back(pick_byte());
            end
            1: msg_q.push_back(8'h00);
            default: begin
                msg_q.push_back(8'($urandom_range(1, 8'hBF)));
                repeat ($urandom_range(0, 5)) msg_q.push_back(8'($urandom_range(1, 255)));
                msg_q.push_back(8'h00);
            end
        endcase
        repeat (8) msg_q.push_back(pick_byte());
        msg_q.push_back(rdlen[15:8]);
        msg_q.push_back(rdlen[7:0]);
    endfunction

    function automatic void trim_to(int keep);
        while (msg_q.size() > keep) void'(msg_q.pop_back());
    endfunction

    function automatic logic [15:0] pick_count();
        case ($urandom_range(0, 3))
            0: return 16'hFFFF;
            1: return 16'h8000;
            2: return 16'($urandom_range(0, 3));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic void build_random();
        int mode, qd, an, rdlen;
        msg_q.delete();
        mode = $urandom_range(0, 99);
        if (mode < 72) begin
            qd = $urandom_range(0, 2);
            an = $urandom_range(0, 3);
            add_header(4'h0, 16'(qd), 16'(an));
            repeat (qd) add_question();
            repeat (an) begin
                rdlen = ($urandom_range(0, 15) == 0) ? $urandom_range(6, 40)
                                                     : $urandom_range(0, 5);
                add_answer_head(16'(rdlen));
                repeat (rdlen) msg_q.push_back(8'($urandom));
            end
            if ($urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, 4)) msg_q.push_back(8'($urandom));
            if (mode >= 58) trim_to($urandom_range(1, msg_q.size()));
        end else if (mode < 82) begin
            add_header(4'($urandom_range(1, 15)), pick_count(), pick_count());
            repeat ($urandom_range(0, 8)) msg_q.push_back(8'($urandom));
            trim_to($urandom_range(4, msg_q.size()));
        end else if (mode < 90) begin
            add_header(4'h0, pick_count(), pick_count());
            repeat ($urandom_range(0, 40)) msg_q.push_back(8'($urandom));
        end else begin
            repeat ($urandom_range(1, 30)) msg_q.push_back(8'($urandom));
        end
    endfunction

    function automatic void build_oversize();
        msg_q.delete();
        add_header(4'h0, 16'h0000, 16'h0001);
        add_answer_head(16'hFFFF);
        while (msg_q.size() < dnsrp_pkg::MSG_BYTES + 24) msg_q.push_back(8'($urandom));
    endfunction

    task automatic push_byte(logic [7:0] b, logic fin);
        int gap;
        gap = pick_gap(send_idle_pct);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= dnsrp_pkg::in_word_t'{msg_byte: b, final_byte: fin};
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        bytes_sent++;
    endtask

    task automatic send_message();
        int pct[4] = '{0, 5, 20, 50};
        send_idle_pct = pct[$urandom_range(0, 3)];
        recv_idle_pct = pct[$urandom_range(0, 3)];
        foreach (msg_q[i]) push_byte(msg_q[i], i == msg_q.size() - 1);
        msgs_sent++;
        if (msgs_sent % 8 == 0) begin
            s_valid <= 1'b0;
            @(negedge aclk);
            while (book.awaited.size() != 0) @(negedge aclk);
        end
    endtask

    initial begin
        int waited;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        m_ready       = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        recv_hold     = 0;
        bytes_sent    = 0;
        msgs_sent     = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // lone final byte, reply error with maximal code in a header cut to five bytes, empty reply
        msg_q = '{8'hFF};
        send_message();
        msg_q.delete();
        add_header(4'hF, 16'hFFFF, 16'hFFFF);
        trim_to(5);
        send_message();
        msg_q.delete();
        add_header(4'h0, 16'h0000, 16'h0000);
        send_message();

        build_oversize();
        send_message();
        while (bytes_sent < ITEM_TARGET) begin
            build_random();
            send_message();
        end
        s_valid <= 1'b0;

        waited = 0;
        while (book.awaited.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (book.awaited.size() != 0)
            book.report($sformatf("%0d results never arrived", book.awaited.size()));
        repeat (20) @(posedge aclk);

        $display("covered %0d messages, %0d bytes, %0d results checked",
                 msgs_sent, bytes_sent, book.checked);
        $display("reply errors %0d, answer headers %0d, rdata words %0d, ends %0d",
                 book.kind_seen[dnsrp_pkg::KIND_ERR], book.kind_seen[dnsrp_pkg::KIND_HEADER],
                 book.kind_seen[dnsrp_pkg::KIND_RDATA], book.kind_seen[dnsrp_pkg::KIND_END]);
        if (book.errors == 0) begin
            $display("tb_dns_response_parser_core: clean");
        end else begin
            $display("tb_dns_response_parser_core: errors");
        end
        $finish;
    end

    initial begin
        #LIMIT_NS;
        $display("timeout with %0d results pending", book.awaited.size());
        $display("tb_dns_response_parser_core: errors");
        $finish;
    end

endmodule
